>>> sv/mvpid_pkg.sv
// ----------------------------------------------------------------------------
// mvpid_pkg
// Shared types and constants for the motor velocity PID block.
// ----------------------------------------------------------------------------
package mvpid_pkg;

  localparam int MUL_W = 64;   // serial multiplier operand/product width
  localparam int DEN_W = 40;   // divider denominator width

  localparam longint MICRO       = 1000000;
  localparam longint DEF_TICK_US = 10000;
  localparam longint W24_MAX     = 8388607;
  localparam longint TERM_SAT    = 64'sd1 << 48;
  localparam longint MIN_BAT_MV  = 1000;

  typedef enum logic [3:0] {
    CFG_GAIN_P     = 4'd0,
    CFG_GAIN_I     = 4'd1,
    CFG_GAIN_D     = 4'd2,
    CFG_ALPHA      = 4'd3,
    CFG_ACCEL      = 4'd4,
    CFG_TOP_SPEED  = 4'd5,
    CFG_NOM_BAT    = 4'd6,
    CFG_DEADBAND   = 4'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FILT_A, ST_FILT_B, ST_STEP_M, ST_STEP_D, ST_INT_M, ST_INT_D,
    ST_P_M, ST_I_M, ST_D_M1, ST_D_M2, ST_D_D, ST_FF_TOP, ST_FF_NUM, ST_FF_D,
    ST_DB_D, ST_SAT_M, ST_DUTY_M, ST_DUTY_D, ST_FIN
  } state_t;

endpackage

>>> sv/motor_velocity_pid.sv
// ----------------------------------------------------------------------------
// motor_velocity_pid
// Velocity PID with EMA filter, accel ramp, feed-forward and duty output.
// ----------------------------------------------------------------------------
// One item at a time. The work is up to six restoring divides plus twelve serial
// multiplies, each multiply stepping through the multiplier bits until none are
// left; a near-zero ramped target skips feed-forward and deadband, and a voltage
// beyond the battery skips the duty divide. The next item is taken once the result
// is in the output register. Reset (rst, sync, high) loads register defaults and
// clears filter, ramp and integral.
module motor_velocity_pid #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // commanded speed, measured speed, battery mV, tick us
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // duty_percent
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int     F      = FRACTION_BITS;
  localparam int     MW     = mvpid_pkg::MUL_W;
  localparam longint ONE    = 64'sd1 << F;
  localparam longint HALF   = 64'sd1 << (F - 1);
  localparam longint THR_I  = (ONE + 50) / 100;
  localparam longint THR_FF = (ONE + 500) / 1000;
  localparam longint ILIM   = (5 * ONE > mvpid_pkg::W24_MAX) ? mvpid_pkg::W24_MAX : 5 * ONE;
  localparam longint DLIM   = (100 * ONE > mvpid_pkg::W24_MAX) ? mvpid_pkg::W24_MAX
                                                                : 100 * ONE;

  // ---- configuration registers ----
  logic [23:0] gain_p, gain_i, gain_d, accel_limit;
  logic [16:0] filter_alpha;
  logic [22:0] top_speed;
  logic [15:0] nom_mv, deadband_mv;

  // ---- item and controller state ----
  mvpid_pkg::state_t state, state_next;
  logic               launched;
  logic signed [23:0] tgt, meas, filt, prev, ramped, integ;
  logic        [15:0] bat;
  logic        [19:0] us;
  logic signed [63:0] t1, dq, pt, it, dt, ff, vv;
  logic        [63:0] tmp;
  logic               tneg;
  logic [mvpid_pkg::DEN_W-1:0] ffden;

  logic [MW-1:0] mul_a, mul_b, mul_prod, div_n, div_q;
  logic [mvpid_pkg::DEN_W-1:0] div_d;
  logic          mul_go, div_go, mul_done, div_done, mul_neg, div_neg, use_div;
  logic signed [63:0] mul_s, div_s;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] apply(input logic [63:0] m, input logic n);
    return n ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clampl(input logic signed [63:0] x,
                                                input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // divide by 2^F, halves away from zero
  function automatic logic signed [63:0] rsh(input logic signed [63:0] x);
    return apply((mag(x) + 64'(HALF)) >> F, x < 0);
  endfunction

  logic [16:0]        a_eff;
  logic signed [24:0] err;
  logic signed [63:0] dfilt, vsum;
  logic [22:0]        top_eff;

  assign a_eff   = (64'(filter_alpha) > 64'(ONE)) ? 17'(ONE) : filter_alpha;
  assign err     = 25'(ramped) - 25'(filt);
  assign dfilt   = 64'(filt) - 64'(prev);
  assign top_eff = (top_speed == '0) ? 23'd1 : top_speed;
  assign mul_s   = apply(mul_prod, mul_neg);
  assign div_s   = apply(div_q, div_neg);

  // operand selection for the shared serial units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    div_n   = '0;
    div_d   = mvpid_pkg::DEN_W'(1);
    div_neg = 1'b0;
    use_div = 1'b0;
    unique case (state)
      mvpid_pkg::ST_FILT_A: begin
        mul_a = MW'(a_eff); mul_b = mag(64'(meas)); mul_neg = meas < 0;
      end
      mvpid_pkg::ST_FILT_B: begin
        mul_a = MW'(ONE) - MW'(a_eff); mul_b = mag(64'(filt)); mul_neg = filt < 0;
      end
      mvpid_pkg::ST_STEP_M: begin
        mul_a = MW'(accel_limit); mul_b = MW'(us);
      end
      mvpid_pkg::ST_STEP_D, mvpid_pkg::ST_INT_D: begin
        use_div = 1'b1; div_n = tmp; div_neg = tneg;
        div_d = mvpid_pkg::DEN_W'(mvpid_pkg::MICRO);
      end
      mvpid_pkg::ST_INT_M: begin
        mul_a = mag(64'(err)); mul_b = MW'(us); mul_neg = err < 0;
      end
      mvpid_pkg::ST_P_M: begin
        mul_a = mag(64'(err)); mul_b = MW'(gain_p); mul_neg = err < 0;
      end
      mvpid_pkg::ST_I_M: begin
        mul_a = mag(64'(integ)); mul_b = MW'(gain_i); mul_neg = integ < 0;
      end
      mvpid_pkg::ST_D_M1: begin
        mul_a = mag(dfilt); mul_b = MW'(gain_d); mul_neg = dfilt < 0;
      end
      mvpid_pkg::ST_D_M2: begin
        mul_a = mag(dq); mul_b = MW'(mvpid_pkg::MICRO); mul_neg = dq < 0;
      end
      mvpid_pkg::ST_D_D: begin
        use_div = 1'b1; div_n = tmp; div_neg = tneg; div_d = mvpid_pkg::DEN_W'(us);
      end
      mvpid_pkg::ST_FF_TOP: begin
        mul_a = MW'(top_eff); mul_b = MW'(1000);
      end
      mvpid_pkg::ST_FF_NUM: begin
        mul_a = mag(64'(ramped)); mul_b = MW'(nom_mv); mul_neg = ramped < 0;
      end
      mvpid_pkg::ST_FF_D: begin
        use_div = 1'b1; div_n = tmp; div_neg = tneg; div_d = ffden;
      end
      mvpid_pkg::ST_DB_D: begin
        use_div = 1'b1; div_n = MW'(deadband_mv) << F; div_d = mvpid_pkg::DEN_W'(1000);
        div_neg = ramped < 0;
      end
      mvpid_pkg::ST_SAT_M: begin
        mul_a = mag(vv); mul_b = MW'(1000);
      end
      mvpid_pkg::ST_DUTY_M: begin
        mul_a = mag(vv); mul_b = MW'(100000); mul_neg = vv < 0;
      end
      mvpid_pkg::ST_DUTY_D: begin
        use_div = 1'b1; div_n = tmp; div_neg = tneg; div_d = mvpid_pkg::DEN_W'(bat);
      end
      default: ;
    endcase
  end

  assign mul_go = (state != mvpid_pkg::ST_IDLE) && (state != mvpid_pkg::ST_FIN)
                  && !launched && !use_div;
  assign div_go = (state != mvpid_pkg::ST_IDLE) && (state != mvpid_pkg::ST_FIN)
                  && !launched && use_div;

  mvpid_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .prod(mul_prod), .done(mul_done)
  );

  mvpid_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_n), .den(div_d),
    .quo(div_q), .done(div_done)
  );

  logic op_done;
  assign op_done   = launched && (use_div ? div_done : mul_done);
  assign s_tready  = (state == mvpid_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign vsum      = ff + apply(mag(div_s), ramped < 0) + pt + it - dt;

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      mvpid_pkg::ST_IDLE:   if (s_tvalid) state_next = mvpid_pkg::ST_FILT_A;
      mvpid_pkg::ST_FILT_A: if (op_done) state_next = mvpid_pkg::ST_FILT_B;
      mvpid_pkg::ST_FILT_B: if (op_done) state_next = mvpid_pkg::ST_STEP_M;
      mvpid_pkg::ST_STEP_M: if (op_done) state_next = mvpid_pkg::ST_STEP_D;
      mvpid_pkg::ST_STEP_D: if (op_done) state_next = mvpid_pkg::ST_INT_M;
      mvpid_pkg::ST_INT_M:  if (op_done) state_next = mvpid_pkg::ST_INT_D;
      mvpid_pkg::ST_INT_D:  if (op_done) state_next = mvpid_pkg::ST_P_M;
      mvpid_pkg::ST_P_M:    if (op_done) state_next = mvpid_pkg::ST_I_M;
      mvpid_pkg::ST_I_M:    if (op_done) state_next = mvpid_pkg::ST_D_M1;
      mvpid_pkg::ST_D_M1:   if (op_done) state_next = mvpid_pkg::ST_D_M2;
      mvpid_pkg::ST_D_M2:   if (op_done) state_next = mvpid_pkg::ST_D_D;
      mvpid_pkg::ST_D_D: begin
        if (op_done) begin
          state_next = (mag(64'(ramped)) > 64'(THR_FF)) ? mvpid_pkg::ST_FF_TOP
                                                       : mvpid_pkg::ST_SAT_M;
        end
      end
      mvpid_pkg::ST_FF_TOP: if (op_done) state_next = mvpid_pkg::ST_FF_NUM;
      mvpid_pkg::ST_FF_NUM: if (op_done) state_next = mvpid_pkg::ST_FF_D;
      mvpid_pkg::ST_FF_D:   if (op_done) state_next = mvpid_pkg::ST_DB_D;
      mvpid_pkg::ST_DB_D:   if (op_done) state_next = mvpid_pkg::ST_SAT_M;
      mvpid_pkg::ST_SAT_M: begin
        if (op_done) begin
          state_next = (mul_prod > (64'(bat) << F)) ? mvpid_pkg::ST_FIN
                                                    : mvpid_pkg::ST_DUTY_M;
        end
      end
      mvpid_pkg::ST_DUTY_M: if (op_done) state_next = mvpid_pkg::ST_DUTY_D;
      mvpid_pkg::ST_DUTY_D: if (op_done) state_next = mvpid_pkg::ST_FIN;
      mvpid_pkg::ST_FIN: begin
        if (!m_tvalid || m_tready) state_next = mvpid_pkg::ST_IDLE;
      end
      default: state_next = mvpid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mvpid_pkg::ST_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_go || div_go) launched <= 1'b1;
      else if (op_done) launched <= 1'b0;
    end
  end

  // config registers, filter/ramp/integral state, datapath captures
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= 24'd65536;
      gain_i       <= '0;
      gain_d       <= '0;
      filter_alpha <= 17'd65536;
      accel_limit  <= 24'd65536;
      top_speed    <= 23'd65536;
      nom_mv       <= 16'd12000;
      deadband_mv  <= '0;
      filt         <= '0;
      prev         <= '0;
      ramped       <= '0;
      integ        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mvpid_pkg::CFG_GAIN_P:    begin gain_p <= cfg_data; integ <= '0; end
          mvpid_pkg::CFG_GAIN_I:    begin gain_i <= cfg_data; integ <= '0; end
          mvpid_pkg::CFG_GAIN_D:    begin gain_d <= cfg_data; integ <= '0; end
          mvpid_pkg::CFG_ALPHA:     filter_alpha <= cfg_data[16:0];
          mvpid_pkg::CFG_ACCEL:     accel_limit <= cfg_data;
          mvpid_pkg::CFG_TOP_SPEED: top_speed <= cfg_data[22:0];
          mvpid_pkg::CFG_NOM_BAT:   nom_mv <= cfg_data[15:0];
          mvpid_pkg::CFG_DEADBAND:  deadband_mv <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        mvpid_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            tgt  <= s_tdata[23:0];
            meas <= s_tdata[47:24];
            us   <= (s_tdata[83:64] == '0) ? 20'(mvpid_pkg::DEF_TICK_US) : s_tdata[83:64];
            if (64'(s_tdata[63:48]) >= 64'(mvpid_pkg::MIN_BAT_MV))
              bat <= s_tdata[63:48];
            else if (64'(nom_mv) >= 64'(mvpid_pkg::MIN_BAT_MV))
              bat <= nom_mv;
            else
              bat <= 16'(mvpid_pkg::MIN_BAT_MV);
          end
        end
        mvpid_pkg::ST_FILT_A: if (op_done) t1 <= mul_s;
        mvpid_pkg::ST_FILT_B: begin
          if (op_done) begin
            prev <= filt;
            filt <= 24'(clampl(rsh(t1 + mul_s), mvpid_pkg::W24_MAX));
          end
        end
        mvpid_pkg::ST_STEP_M: if (op_done) begin tmp <= mul_prod; tneg <= 1'b0; end
        mvpid_pkg::ST_STEP_D: begin
          // ramp toward target by at most the step
          if (op_done) ramped <= 24'(64'(ramped) + clampl(64'(tgt) - 64'(ramped), div_q));
        end
        mvpid_pkg::ST_INT_M: if (op_done) begin tmp <= mul_prod; tneg <= mul_neg; end
        mvpid_pkg::ST_INT_D: begin
          if (op_done) begin
            if (mag(64'(ramped)) < 64'(THR_I)) integ <= '0;
            else integ <= 24'(clampl(64'(integ) + div_s, ILIM));
          end
        end
        mvpid_pkg::ST_P_M:  if (op_done) pt <= clampl(rsh(mul_s), mvpid_pkg::TERM_SAT);
        mvpid_pkg::ST_I_M:  if (op_done) it <= clampl(rsh(mul_s), mvpid_pkg::TERM_SAT);
        mvpid_pkg::ST_D_M1: if (op_done) dq <= rsh(mul_s);
        mvpid_pkg::ST_D_M2: if (op_done) begin tmp <= mul_prod; tneg <= mul_neg; end
        mvpid_pkg::ST_D_D: begin
          if (op_done) begin
            dt <= clampl(div_s, mvpid_pkg::TERM_SAT);
            vv <= '0;
          end
        end
        mvpid_pkg::ST_FF_TOP: if (op_done) ffden <= mvpid_pkg::DEN_W'(mul_prod);
        mvpid_pkg::ST_FF_NUM: if (op_done) begin tmp <= mul_prod << F; tneg <= mul_neg; end
        mvpid_pkg::ST_FF_D:   if (op_done) ff <= clampl(div_s, mvpid_pkg::TERM_SAT);
        mvpid_pkg::ST_DB_D:   if (op_done) vv <= vsum;
        mvpid_pkg::ST_SAT_M: begin
          // voltage beyond the battery: full duty in the sign of v
          if (op_done) t1 <= (vv < 0) ? -64'(DLIM) : 64'(DLIM);
        end
        mvpid_pkg::ST_DUTY_M: if (op_done) begin tmp <= mul_prod; tneg <= mul_neg; end
        mvpid_pkg::ST_DUTY_D: if (op_done) t1 <= clampl(div_s, DLIM);
        default: ;
      endcase
      // output register: load a new duty item when free or being drained
      if (state == mvpid_pkg::ST_FIN && (!m_tvalid || m_tready)) begin
        m_tdata  <= t1[23:0];
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/mvpid_mul.sv
// ----------------------------------------------------------------------------
// mvpid_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, early exit.
// ----------------------------------------------------------------------------
module mvpid_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mvpid_pkg::MUL_W-1:0]  a,
  input  logic [mvpid_pkg::MUL_W-1:0]  b,
  output logic [mvpid_pkg::MUL_W-1:0]  prod,
  output logic                         done
);

  logic                        busy;
  logic [mvpid_pkg::MUL_W-1:0] mcand;
  logic [mvpid_pkg::MUL_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && mplier == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= '0;
      mcand  <= a;
      mplier <= b;
    end else if (busy && mplier != '0) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

>>> sv/mvpid_div.sv
// ----------------------------------------------------------------------------
// mvpid_div
// Restoring divider, one quotient bit per cycle, rounds half up on magnitudes.
// ----------------------------------------------------------------------------
module mvpid_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mvpid_pkg::MUL_W-1:0]  num,
  input  logic [mvpid_pkg::DEN_W-1:0]  den,
  output logic [mvpid_pkg::MUL_W-1:0]  quo,
  output logic                         done
);

  localparam int CW = $clog2(mvpid_pkg::MUL_W + 1);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [mvpid_pkg::DEN_W-1:0] dreg;
  logic [mvpid_pkg::DEN_W-1:0] rem;
  logic [mvpid_pkg::DEN_W:0]   trial;
  logic                        fits;

  assign trial = {rem, quo[mvpid_pkg::MUL_W-1]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(mvpid_pkg::MUL_W);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= den;
      rem  <= '0;
      quo  <= num + mvpid_pkg::MUL_W'(den >> 1);
    end else if (busy && cnt != '0) begin
      rem <= fits ? mvpid_pkg::DEN_W'(trial - {1'b0, dreg})
                  : trial[mvpid_pkg::DEN_W-1:0];
      quo <= {quo[mvpid_pkg::MUL_W-2:0], fits};
    end
  end

endmodule
